// ===== rtl/core/urlpd_pkg.sv =====
// ---------------------------------------------------------------------------
// urlpd_pkg
// Types, character codes and helpers shared by the URL percent decoder.
// ---------------------------------------------------------------------------
package urlpd_pkg;

   // escape tracking state
   localparam logic [1:0] HELD_IDLE  = 2'd0;
   localparam logic [1:0] HELD_PCT   = 2'd1;
   localparam logic [1:0] HELD_DIGIT = 2'd2;

   // control register indexes
   localparam logic CSR_PLUS_AS_SPACE = 1'b0;
   localparam logic CSR_OUTPUT_LIMIT  = 1'b1;

   localparam int CSR_DATA_BITS = 16;
   localparam int MAX_WORDS     = 3;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   // one decode step, as seen by the output side
   typedef struct packed {
      logic [1:0]      held;       // escape state after the step
      logic [7:0]      digit;      // held hex digit after the step
      logic [1:0]      n_emit;     // bytes that count against the limit
      logic [1:0]      n_words;    // words to send (0..3)
      logic [2:0][7:0] bytes;      // word payloads, first word in [0]
      logic            byte_valid; // 0 only for a bare end marker
      logic            dropped;    // dropped flag after the step
   } dec_type;

   // {valid, nibble} of an ASCII hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      case (c) inside
         [8'h30:8'h39]: r = {1'b1, c[3:0]};
         [8'h41:8'h46],
         [8'h61:8'h66]: r = {1'b1, 4'(c[3:0] + 4'd9)};
         default:       r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/urlpd_if.sv =====
// ---------------------------------------------------------------------------
// urlpd_if
// Valid/ready channels of the URL percent decoder: encoded bytes in,
// decoded words out.
// ---------------------------------------------------------------------------
interface urlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface urlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_string;
   logic       truncated;

   modport source (output valid, output out_byte, output byte_valid,
                   output end_of_string, output truncated, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input end_of_string, input truncated, output ready);
endinterface

// ===== rtl/core/urlpd_decode.sv =====
// ---------------------------------------------------------------------------
// urlpd_decode
// One decode step: escape tracking, form/raw plus handling, flush at end of
// string and the output limit check, all as one combinational pass.
// ---------------------------------------------------------------------------
module urlpd_decode #(
   parameter int COUNT_BITS = 16
) (
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   input  logic [1:0]            held,
   input  logic [7:0]            digit,
   input  logic [COUNT_BITS-1:0] count,
   input  logic                  dropped,
   input  logic                  plus_as_space,
   input  logic [15:0]           output_limit,
   output urlpd_pkg::dec_type    dec
);

   localparam int XW = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 2;

   logic [4:0]      hex_in;
   logic [4:0]      hex_held;
   logic [2:0][7:0] cand;
   logic [1:0]      n_cand;
   logic [1:0]      nh;
   logic [7:0]      nd;
   logic            do_plain;
   logic [2:0]      ok;
   logic [1:0]      n_emit;
   logic [XW-1:0]   cnt_x;
   logic [XW-1:0]   lim_x;
   logic [XW-1:0]   max_x;

   assign hex_in   = urlpd_pkg::hex_decode(in_byte);
   assign hex_held = urlpd_pkg::hex_decode(digit);

   // candidate bytes in emit order
   always_comb begin
      cand     = '0;
      n_cand   = 2'd0;
      nh       = urlpd_pkg::HELD_IDLE;
      nd       = digit;
      do_plain = 1'b0;
      case (held)
         urlpd_pkg::HELD_PCT: begin
            if (hex_in[4]) begin
               nh = urlpd_pkg::HELD_DIGIT;
               nd = in_byte;
            end else begin
               cand[0]  = urlpd_pkg::CH_PERCENT;
               n_cand   = 2'd1;
               do_plain = 1'b1;
            end
         end
         urlpd_pkg::HELD_DIGIT: begin
            if (hex_in[4]) begin
               cand[0] = {(hex_held[4] ? hex_held[3:0] : 4'd0), hex_in[3:0]};
               n_cand  = 2'd1;
            end else begin
               cand[0]  = urlpd_pkg::CH_PERCENT;
               cand[1]  = digit;
               n_cand   = 2'd2;
               do_plain = 1'b1;
            end
         end
         default: begin
            do_plain = 1'b1;
         end
      endcase

      if (do_plain) begin
         if (in_byte == urlpd_pkg::CH_PERCENT) begin
            nh = urlpd_pkg::HELD_PCT;
         end else begin
            cand[n_cand] = (in_byte == urlpd_pkg::CH_PLUS && plus_as_space) ?
                           urlpd_pkg::CH_SPACE : in_byte;
            n_cand = n_cand + 2'd1;
         end
      end

      // flush a cut-off escape literally
      if (in_last) begin
         if (nh == urlpd_pkg::HELD_PCT) begin
            cand[n_cand] = urlpd_pkg::CH_PERCENT;
            n_cand       = n_cand + 2'd1;
         end else if (nh == urlpd_pkg::HELD_DIGIT) begin
            cand[0] = urlpd_pkg::CH_PERCENT;
            cand[1] = nd;
            n_cand  = 2'd2;
         end
         nh = urlpd_pkg::HELD_IDLE;
      end
   end

   // limit check for the next three slots; saturating counter caps it too
   assign cnt_x = XW'(count);
   assign lim_x = XW'(output_limit);
   assign max_x = (XW'(1) << COUNT_BITS) - XW'(1);

   always_comb begin
      for (int k = 0; k < urlpd_pkg::MAX_WORDS; k++) begin
         ok[k] = (cnt_x + XW'(k) < lim_x) && (cnt_x + XW'(k) < max_x);
      end
   end

   always_comb begin
      n_emit = 2'd0;
      if (n_cand >= 2'd1 && ok[0]) begin
         n_emit = 2'd1;
         if (n_cand >= 2'd2 && ok[1]) begin
            n_emit = 2'd2;
            if (n_cand >= 2'd3 && ok[2]) begin
               n_emit = 2'd3;
            end
         end
      end
   end

   always_comb begin
      dec.held       = nh;
      dec.digit      = nd;
      dec.n_emit     = n_emit;
      dec.n_words    = (n_emit == 2'd0) ? {1'b0, in_last} : n_emit;
      dec.bytes      = (n_emit == 2'd0) ? '0 : cand;
      dec.byte_valid = (n_emit != 2'd0);
      dec.dropped    = dropped | (n_cand != n_emit);
   end

endmodule

// ===== rtl/core/url_percent_decoder.sv =====
// ---------------------------------------------------------------------------
// url_percent_decoder
// Streams a URL-encoded string through one byte at a time and delivers the
// decoded bytes, with plus-as-space, an output limit and an end marker.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake     payload
//  req_chan  in         valid/ready   in_byte[7:0], in_last
//  rsp_chan  out        valid/ready   out_byte[7:0], byte_valid, end_of_string,
//                                     truncated
//  csr_*     in         csr_we        csr_index, csr_data[15:0] (write only)
//
//  One input word per cycle while each word yields at most one result word. A
//  word yielding k output words (an escape flushed literally: up to three)
//  holds the input side until its last word leaves; the single output port
//  sets this. Words pass the input register, then the result group register.
//  Reset is synchronous and brings the controls back to form decoding with the
//  full limit. Either side may stall at any time; nothing is lost.
//
module url_percent_decoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   urlpd_req_if.sink                           req_chan,
   urlpd_rsp_if.source                         rsp_chan,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [urlpd_pkg::CSR_DATA_BITS-1:0] csr_data
);

   // control registers
   logic        plus_as_space_ff;
   logic [15:0] output_limit_ff;

   // input register
   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   // string state
   logic [1:0]            held_count_ff;
   logic [7:0]            held_digit_ff;
   logic [COUNT_BITS-1:0] emitted_count_ff;
   logic                  dropped_flag_ff;

   // result group register
   logic [1:0]      grp_n_ff;
   logic [1:0]      grp_n_in;
   logic [1:0]      grp_idx_ff;
   logic [1:0]      grp_idx_in;
   logic [2:0][7:0] grp_bytes_ff;
   logic            grp_bv_ff;
   logic            grp_eos_ff;
   logic            grp_trunc_ff;

   urlpd_pkg::dec_type dec;

   logic req_take;
   logic rsp_take;
   logic grp_last;
   logic grp_free;
   logic dec_fire;

   // -- handshakes ----------------------------------------------------------
   assign rsp_take = rsp_chan.valid && rsp_chan.ready;
   assign grp_last = (grp_idx_ff == grp_n_ff - 2'd1);
   // group can take a new step when empty or when its final word leaves now
   assign grp_free = (grp_n_ff == 2'd0) || (rsp_take && grp_last);
   assign dec_fire = in_valid_ff && grp_free;

   // input register refills while its word moves on into the group register
   assign req_chan.ready = !in_valid_ff || dec_fire;
   assign req_take       = req_chan.valid && req_chan.ready;

   // -- control writes ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         plus_as_space_ff <= 1'b1;
         output_limit_ff  <= 16'hFFFF;
      end else if (csr_we) begin
         case (csr_index)
            urlpd_pkg::CSR_PLUS_AS_SPACE: plus_as_space_ff <= csr_data[0];
            urlpd_pkg::CSR_OUTPUT_LIMIT:  output_limit_ff  <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // -- input register ------------------------------------------------------
   assign in_valid_in = req_take || (in_valid_ff && !dec_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.in_last;
      end
   end

   // -- decode step ---------------------------------------------------------
   urlpd_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .in_byte       (in_byte_ff),
      .in_last       (in_last_ff),
      .held          (held_count_ff),
      .digit         (held_digit_ff),
      .count         (emitted_count_ff),
      .dropped       (dropped_flag_ff),
      .plus_as_space (plus_as_space_ff),
      .output_limit  (output_limit_ff),
      .dec           (dec)
   );

   // advance string state on each step; end of string clears the counters
   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff    <= urlpd_pkg::HELD_IDLE;
         held_digit_ff    <= 8'd0;
         emitted_count_ff <= '0;
         dropped_flag_ff  <= 1'b0;
      end else if (dec_fire) begin
         held_count_ff <= dec.held;
         held_digit_ff <= dec.digit;
         if (in_last_ff) begin
            emitted_count_ff <= '0;
            dropped_flag_ff  <= 1'b0;
         end else begin
            emitted_count_ff <= emitted_count_ff + COUNT_BITS'(dec.n_emit);
            dropped_flag_ff  <= dec.dropped;
         end
      end
   end

   // -- result group --------------------------------------------------------
   always_comb begin
      grp_n_in   = grp_n_ff;
      grp_idx_in = grp_idx_ff;
      if (dec_fire) begin
         grp_n_in   = dec.n_words;
         grp_idx_in = 2'd0;
      end else if (rsp_take) begin
         if (grp_last) begin
            grp_n_in   = 2'd0;
            grp_idx_in = 2'd0;
         end else begin
            grp_idx_in = grp_idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_n_ff   <= 2'd0;
         grp_idx_ff <= 2'd0;
      end else begin
         grp_n_ff   <= grp_n_in;
         grp_idx_ff <= grp_idx_in;
      end
   end

   // hold the payload of the group until the next step replaces it
   always_ff @(posedge clock) begin
      if (dec_fire) begin
         grp_bytes_ff <= dec.bytes;
         grp_bv_ff    <= dec.byte_valid;
         grp_eos_ff   <= in_last_ff;
         grp_trunc_ff <= dec.dropped;
      end
   end

   assign rsp_chan.valid         = (grp_n_ff != 2'd0);
   assign rsp_chan.out_byte      = grp_bytes_ff[grp_idx_ff];
   assign rsp_chan.byte_valid    = grp_bv_ff;
   assign rsp_chan.end_of_string = grp_eos_ff && grp_last;
   assign rsp_chan.truncated     = grp_trunc_ff;

   // -- checks --------------------------------------------------------------
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (grp_idx_ff < grp_n_ff))
      else $error("word index beyond the result group");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (dec_fire && in_last_ff) |=>
         (emitted_count_ff == '0 && held_count_ff == urlpd_pkg::HELD_IDLE
          && !dropped_flag_ff))
      else $error("string state not cleared at end of string");

   a_held_code: assert property (@(posedge clock) disable iff (reset)
      held_count_ff != 2'd3)
      else $error("escape state holds an unused code");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.byte_valid) |->
         (rsp_chan.end_of_string && grp_n_ff == 2'd1))
      else $error("empty word that is not a lone end marker");

endmodule

// ===== verif/url_percent_decoder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// url_percent_decoder_tb
// Drives encoded strings into the decoder through its valid/ready channels,
// predicts every decoded word from a local model of the escape state and the
// output limit, and checks each word as it leaves.
// ---------------------------------------------------------------------------
module url_percent_decoder_tb;

   // one decoded word as it leaves the block
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_string;
      logic       truncated;
   } dec_word_type;

   // one encoded word waiting to be offered
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } enc_word_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_we;
   logic                                csr_index;
   logic [urlpd_pkg::CSR_DATA_BITS-1:0] csr_data;

   urlpd_req_if req_chan ();
   urlpd_rsp_if rsp_chan ();

   url_percent_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // stimulus backlog and decoded words still owed by the block
   enc_word_type encoded_backlog[$];
   dec_word_type decoded_due[$];
   dec_word_type step_words[$];

   // local copy of the decoder state and its controls
   logic [1:0]  mdl_held;
   logic [7:0]  mdl_digit;
   logic [15:0] mdl_count;
   logic        mdl_dropped;
   logic        mdl_plus;
   logic [15:0] mdl_limit;

   int src_idle_pct;
   int snk_stall_pct;
   int hold_left;
   logic hold_arm;
   int mismatch_count;

   always #4 clock = ~clock;

   // -----------------------------------------------------------------------
   // Decoder model
   // -----------------------------------------------------------------------

   // nibble of an ASCII hex digit, -1 for anything else
   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   // emit one byte unless the limit or the counter ceiling stops it
   function automatic void put_byte(input logic [7:0] b);
      dec_word_type w;
      if (mdl_count < mdl_limit && mdl_count != 16'hFFFF &&
          step_words.size() < urlpd_pkg::MAX_WORDS) begin
         w = '{out_byte: b, byte_valid: 1'b1, end_of_string: 1'b0, truncated: 1'b0};
         step_words.push_back(w);
         mdl_count = mdl_count + 16'd1;
      end else begin
         mdl_dropped = 1'b1;
      end
   endfunction

   // a byte seen outside any escape
   function automatic void plain_byte(input logic [7:0] b);
      if (b == urlpd_pkg::CH_PERCENT) begin
         mdl_held = urlpd_pkg::HELD_PCT;
      end else if (b == urlpd_pkg::CH_PLUS && mdl_plus) begin
         put_byte(urlpd_pkg::CH_SPACE);
      end else begin
         put_byte(b);
      end
   endfunction

   // advance the model by one accepted word and queue what it owes
   function automatic void decode_step(input logic [7:0] b, input logic last);
      dec_word_type w;
      int           hi;
      int           lo;
      step_words.delete();
      case (mdl_held)
         urlpd_pkg::HELD_PCT: begin
            if (nibble_of(b) >= 0) begin
               mdl_digit = b;
               mdl_held  = urlpd_pkg::HELD_DIGIT;
            end else begin
               mdl_held = urlpd_pkg::HELD_IDLE;
               put_byte(urlpd_pkg::CH_PERCENT);
               plain_byte(b);
            end
         end
         urlpd_pkg::HELD_DIGIT: begin
            lo       = nibble_of(b);
            mdl_held = urlpd_pkg::HELD_IDLE;
            if (lo >= 0) begin
               hi = nibble_of(mdl_digit);
               if (hi < 0) hi = 0;
               put_byte(8'((hi << 4) | lo));
            end else begin
               // broken escape: give back what was held, then decode afresh
               put_byte(urlpd_pkg::CH_PERCENT);
               put_byte(mdl_digit);
               plain_byte(b);
            end
         end
         default: begin
            mdl_held = urlpd_pkg::HELD_IDLE;
            plain_byte(b);
         end
      endcase

      if (last) begin
         // flush an escape cut off by the end of the string
         if (mdl_held == urlpd_pkg::HELD_PCT) begin
            put_byte(urlpd_pkg::CH_PERCENT);
         end else if (mdl_held == urlpd_pkg::HELD_DIGIT) begin
            put_byte(urlpd_pkg::CH_PERCENT);
            put_byte(mdl_digit);
         end
         mdl_held = urlpd_pkg::HELD_IDLE;
         // nothing went out: the end mark travels alone
         if (step_words.size() == 0) begin
            step_words.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
         end
      end

      foreach (step_words[i]) begin
         w = step_words[i];
         w.truncated = mdl_dropped;
         if (last && i == step_words.size() - 1) w.end_of_string = 1'b1;
         decoded_due.push_back(w);
      end

      if (last) begin
         mdl_count   = 16'd0;
         mdl_dropped = 1'b0;
      end
   endfunction

   // -----------------------------------------------------------------------
   // Request driver: offer backlog words, idle at random
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      enc_word_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         // the word on the wires was taken: advance the model
         if (req_chan.valid && req_chan.ready) begin
            decode_step(req_chan.in_byte, req_chan.in_last);
         end
         // hold the current word until it is taken
         if (!req_chan.valid || req_chan.ready) begin
            if (encoded_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
               nxt = encoded_backlog.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.in_byte <= nxt.in_byte;
               req_chan.in_last <= nxt.in_last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Long receiver hold-off, counted on its own
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm) begin
         hold_left <= 400;
      end
   end

   // -----------------------------------------------------------------------
   // Response monitor: check each word against the oldest one owed
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      dec_word_type got;
      dec_word_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{out_byte:      rsp_chan.out_byte,
                    byte_valid:    rsp_chan.byte_valid,
                    end_of_string: rsp_chan.end_of_string,
                    truncated:     rsp_chan.truncated};
            if (decoded_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected word: byte %02h valid %0b end %0b trunc %0b",
                           $realtime, got.out_byte, got.byte_valid, got.end_of_string,
                           got.truncated);
            end else begin
               want = decoded_due.pop_front();
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.end_of_string !== want.end_of_string ||
                   got.truncated !== want.truncated) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"[%0t] mismatch: want byte %02h valid %0b end %0b trunc %0b,",
                               " got byte %02h valid %0b end %0b trunc %0b"},
                              $realtime, want.out_byte, want.byte_valid,
                              want.end_of_string, want.truncated, got.out_byte,
                              got.byte_valid, got.end_of_string, got.truncated);
               end
            end
         end
         // stall during the long hold-off, otherwise at random
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= snk_stall_pct);
      end
   end

   // -----------------------------------------------------------------------
   // Stimulus helpers
   // -----------------------------------------------------------------------
   function automatic void push_word(input logic [7:0] b, input logic last);
      encoded_backlog.push_back('{in_byte: b, in_last: last});
   endfunction

   // hex digit for a nibble, letters in either case
   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      if ($urandom_range(0, 1) != 0) return 8'h41 + 8'(v) - 8'd10;
      return 8'h61 + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (nibble_of(c) >= 0);
      return c;
   endfunction

   // build one encoded string, mostly well formed; return its length
   function automatic int queue_string();
      logic [7:0] text[$];
      int         n_tokens;
      int         pick;
      logic [7:0] v;
      n_tokens = $urandom_range(1, 6);
      if ($urandom_range(0, 99) < 15) begin
         // noise: raw bytes of any value
         repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (n_tokens) begin
            pick = $urandom_range(0, 99);
            v    = 8'($urandom);
            if (pick < 35) begin
               text.push_back(v);
            end else if (pick < 60) begin
               text.push_back(urlpd_pkg::CH_PERCENT);
               text.push_back(hex_char(v[7:4]));
               text.push_back(hex_char(v[3:0]));
            end else if (pick < 70) begin
               text.push_back(urlpd_pkg::CH_PLUS);
            end else if (pick < 78) begin
               text.push_back(urlpd_pkg::CH_PERCENT);
               text.push_back(non_hex_char());
            end else if (pick < 86) begin
               text.push_back(urlpd_pkg::CH_PERCENT);
               text.push_back(hex_char(v[3:0]));
               text.push_back(non_hex_char());
            end else if (pick < 90) begin
               // %u form is not decoded and must pass through literally
               text.push_back(urlpd_pkg::CH_PERCENT);
               text.push_back("u");
               repeat (4) text.push_back(hex_char(4'($urandom)));
            end else begin
               // dangling escape, cut off if it ends the string
               text.push_back(urlpd_pkg::CH_PERCENT);
               if (v[0]) text.push_back(hex_char(v[7:4]));
            end
         end
      end
      foreach (text[i]) push_word(text[i], i == text.size() - 1);
      return text.size();
   endfunction

   function automatic void queue_strings(input int n_words);
      int total;
      total = 0;
      while (total < n_words) total += queue_string();
   endfunction

   // wait until nothing is owed and the block has had time to settle
   task automatic drain();
      int quiet;
      quiet = 0;
      while (quiet < 12) begin
         @(posedge clock);
         if (encoded_backlog.size() != 0 || req_chan.valid || decoded_due.size() != 0)
            quiet = 0;
         else
            quiet++;
      end
   endtask

   // write a control register; only called while the block is idle
   task automatic write_csr(input logic idx,
                            input logic [urlpd_pkg::CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == urlpd_pkg::CSR_PLUS_AS_SPACE) mdl_plus = val[0];
      else mdl_limit = val;
   endtask

   task automatic set_idling(input int src_pct, input int snk_pct);
      @(posedge clock);
      src_idle_pct  <= src_pct;
      snk_stall_pct <= snk_pct;
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = urlpd_pkg::CSR_PLUS_AS_SPACE;
      csr_data         = '0;
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h00;
      req_chan.in_last = 1'b0;
      rsp_chan.ready   = 1'b0;
      src_idle_pct     = 0;
      snk_stall_pct    = 0;
      hold_arm         = 1'b0;
      mismatch_count   = 0;
      // model comes up with the block's reset controls
      mdl_held    = urlpd_pkg::HELD_IDLE;
      mdl_digit   = 8'h00;
      mdl_count   = 16'd0;
      mdl_dropped = 1'b0;
      mdl_plus    = 1'b1;
      mdl_limit   = 16'hFFFF;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: reset controls, form decoding, full limit
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // escape spelling zero
      push_word("0", 1'b0);
      push_word("0", 1'b0);
      push_word(8'hFF, 1'b0);                   // top byte copied
      push_word(urlpd_pkg::CH_PLUS, 1'b0);      // plus becomes space
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // mixed-case escape
      push_word("f", 1'b0);
      push_word("A", 1'b0);
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // percent breaks percent, then %41
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);
      push_word("4", 1'b0);
      push_word("1", 1'b0);
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // non-hex right after percent
      push_word("g", 1'b0);
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // non-hex after one digit: three words
      push_word("a", 1'b0);
      push_word("z", 1'b0);
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // %u stays literal
      push_word("u", 1'b0);
      push_word(urlpd_pkg::CH_PERCENT, 1'b0);   // escape cut off after one digit
      push_word("7", 1'b1);
      push_word(urlpd_pkg::CH_PERCENT, 1'b1);   // lone percent ends the string
      drain();

      // raw decoding; receiver holds off for a long stretch while input piles up
      write_csr(urlpd_pkg::CSR_PLUS_AS_SPACE, '0);
      write_csr(urlpd_pkg::CSR_OUTPUT_LIMIT, 16'hFFFF);
      set_idling(0, 0);
      hold_arm <= 1'b1;
      @(posedge clock);
      hold_arm <= 1'b0;
      queue_strings(55);
      drain();

      // tight limit, sender idles
      write_csr(urlpd_pkg::CSR_PLUS_AS_SPACE, 16'd1);
      write_csr(urlpd_pkg::CSR_OUTPUT_LIMIT, 16'd3);
      set_idling(53, 0);
      queue_strings(55);
      drain();

      // nothing may be emitted: every string ends in a bare end mark
      write_csr(urlpd_pkg::CSR_PLUS_AS_SPACE, '0);
      write_csr(urlpd_pkg::CSR_OUTPUT_LIMIT, 16'd0);
      set_idling(0, 53);
      queue_strings(35);
      drain();

      // single-byte limit, then a modest one, both sides idling
      write_csr(urlpd_pkg::CSR_PLUS_AS_SPACE, 16'd1);
      write_csr(urlpd_pkg::CSR_OUTPUT_LIMIT, 16'd1);
      set_idling(24, 24);
      queue_strings(30);
      drain();
      write_csr(urlpd_pkg::CSR_OUTPUT_LIMIT, 16'd7);
      queue_strings(35);
      drain();

      if (decoded_due.size() != 0) begin
         mismatch_count++;
         $display("%0d decoded words never arrived", decoded_due.size());
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
